### src/swstat_pkg.sv
package swstat_pkg;

	localparam int SUM_W = 42;
	localparam int VAL_W = 18;
	localparam int OUT_CNT_W = 24;
	localparam int NUM_CH = 7;
	localparam int NUM_SUM = 4;

	localparam logic [2:0] CH_COLOUR = 3'd7;

	localparam logic [1:0] COL_NONE  = 2'd0;
	localparam logic [1:0] COL_RED   = 2'd1;
	localparam logic [1:0] COL_GREEN = 2'd2;
	localparam logic [1:0] COL_BLUE  = 2'd3;

	localparam logic REG_CLEAR_SAT = 1'b0;
	localparam logic REG_DARK      = 1'b1;

	localparam logic [15:0] CLEAR_SAT_RESET = 16'd6000;
	localparam logic [15:0] DARK_RESET      = 16'd100;

	typedef struct packed {
		logic               action;
		logic [15:0]        light;
		logic [15:0]        moisture;
		logic signed [17:0] temperature;
		logic [16:0]        humidity;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic [1:0]         colour;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### src/swstat_front.sv
module swstat_front import swstat_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         s_tvalid,
	input  logic         s_tuser,
	input  logic [183:0] s_tdata,
	output logic         s_tready,
	input  q_stat_t      q_stat,
	output logic         push,
	output item_t        push_item
);

	logic [15:0] clear_sat_q;
	logic [15:0] dark_q;
	logic [15:0] c_lvl, r_lvl, g_lvl, b_lvl;
	logic [1:0]  colour;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_sat_q <= CLEAR_SAT_RESET;
			dark_q      <= DARK_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_CLEAR_SAT: clear_sat_q <= cfg_data;
				REG_DARK:      dark_q      <= cfg_data;
				default:       ;
			endcase
		end
	end

	assign c_lvl = s_tdata[130:115];
	assign r_lvl = s_tdata[146:131];
	assign g_lvl = s_tdata[162:147];
	assign b_lvl = s_tdata[178:163];

	always_comb begin
		colour = COL_NONE;
		if (c_lvl > clear_sat_q) begin
			colour = COL_NONE;
		end else if (r_lvl < dark_q && g_lvl < dark_q && b_lvl < dark_q) begin
			colour = COL_NONE;
		end else if (r_lvl > g_lvl && r_lvl >= b_lvl) begin
			colour = COL_RED;
		end else if (g_lvl > r_lvl && g_lvl > b_lvl) begin
			colour = COL_GREEN;
		end else if (b_lvl > r_lvl && b_lvl > g_lvl) begin
			colour = COL_BLUE;
		end
	end

	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && !q_stat.full;

	always_comb begin
		push_item.action      = s_tuser;
		push_item.light       = s_tdata[15:0];
		push_item.moisture    = s_tdata[31:16];
		push_item.temperature = s_tdata[49:32];
		push_item.humidity    = s_tdata[66:50];
		push_item.accel_x     = s_tdata[82:67];
		push_item.accel_y     = s_tdata[98:83];
		push_item.accel_z     = s_tdata[114:99];
		push_item.colour      = colour;
	end

endmodule

### src/swstat_fifo.sv
module swstat_fifo import swstat_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_item,
	input  logic    pop,
	output item_t   pop_item,
	output q_stat_t q_stat
);

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

	assign pop_item     = mem_q[rd_q];
	assign q_stat.full  = cnt_q == 2'd2;
	assign q_stat.empty = cnt_q == 2'd0;

endmodule

### src/swstat_back.sv
module swstat_back import swstat_pkg::*; #(
	parameter int COUNT_BITS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  q_stat_t      q_stat,
	input  item_t        pop_item,
	output logic         pop,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [2:0]   m_tuser,
	output logic         m_tlast,
	output logic [103:0] m_tdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [1:0]                state_q;
	logic [2:0]                ch_q;
	logic [COUNT_BITS-1:0]     cnt_q;
	logic                      has_q;
	logic signed [SUM_W-1:0]   sum_q   [NUM_SUM];
	logic signed [VAL_W-1:0]   min_q   [NUM_CH];
	logic signed [VAL_W-1:0]   max_q   [NUM_CH];
	logic [COUNT_BITS-1:0]     tally_q [3];
	logic                      neg_q;
	logic [SUM_W-1:0]          dvd_q;
	logic [COUNT_BITS-1:0]     rem_q;
	logic [5:0]                step_q;

	logic                      out_valid_q;
	logic [2:0]                out_ch_q;
	logic                      out_last_q;
	logic [103:0]              out_data_q;

	logic signed [VAL_W-1:0]   v [NUM_CH];
	logic signed [SUM_W:0]     sum_n [NUM_SUM];
	logic signed [SUM_W-1:0]   sum_sel;
	logic [COUNT_BITS:0]       rem_sh;
	logic                      ge;
	logic [COUNT_BITS:0]       rem_n;
	logic                      has_div;
	logic signed [VAL_W-1:0]   mean_val;
	logic signed [VAL_W-1:0]   min_val;
	logic signed [VAL_W-1:0]   max_val;
	logic [1:0]                dom;
	logic [COUNT_BITS-1:0]     dom_cnt;
	logic                      load_out;
	logic                      sample;

	function automatic logic [OUT_CNT_W-1:0] cnt_out(input logic [COUNT_BITS-1:0] c);
		logic [31:0] c32;
		c32 = 32'(c);
		return (c32 > 32'(24'hFFFFFF)) ? {OUT_CNT_W{1'b1}} : c32[OUT_CNT_W-1:0];
	endfunction

	assign pop    = state_q == ST_IDLE && !q_stat.empty;
	assign sample = pop && !pop_item.action;

	always_comb begin
		v[0] = {2'b00, pop_item.light};
		v[1] = {2'b00, pop_item.moisture};
		v[2] = pop_item.temperature;
		v[3] = {1'b0, pop_item.humidity};
		v[4] = VAL_W'(pop_item.accel_x);
		v[5] = VAL_W'(pop_item.accel_y);
		v[6] = VAL_W'(pop_item.accel_z);
		for (int i = 0; i < NUM_SUM; i++) begin
			sum_n[i] = (SUM_W+1)'(sum_q[i]) + (SUM_W+1)'(v[i]);
		end
	end

	assign sum_sel = sum_q[ch_q[1:0]];
	assign rem_sh  = {rem_q, dvd_q[SUM_W-1]};
	assign ge      = rem_sh >= {1'b0, cnt_q};
	assign rem_n   = ge ? (rem_sh - {1'b0, cnt_q}) : rem_sh;
	assign has_div = !ch_q[2] && cnt_q != '0;
	assign load_out = state_q == ST_EMIT && (!out_valid_q || m_tready);

	always_comb begin
		mean_val = '0;
		min_val  = '0;
		max_val  = '0;
		if (has_div) begin
			mean_val = neg_q ? -$signed(dvd_q[VAL_W-1:0]) : $signed(dvd_q[VAL_W-1:0]);
		end
		if (ch_q != CH_COLOUR) begin
			min_val = min_q[ch_q];
			max_val = max_q[ch_q];
		end
		dom     = COL_NONE;
		dom_cnt = '0;
		if (tally_q[0] > tally_q[1] && tally_q[0] > tally_q[2]) begin
			dom     = COL_RED;
			dom_cnt = tally_q[0];
		end else if (tally_q[1] > tally_q[0] && tally_q[1] > tally_q[2]) begin
			dom     = COL_GREEN;
			dom_cnt = tally_q[1];
		end else if (tally_q[2] > tally_q[0] && tally_q[2] > tally_q[1]) begin
			dom     = COL_BLUE;
			dom_cnt = tally_q[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
			cnt_q   <= '0;
			has_q   <= 1'b0;
			step_q  <= '0;
			for (int i = 0; i < NUM_SUM; i++) sum_q[i] <= '0;
			for (int i = 0; i < NUM_CH; i++) begin
				min_q[i] <= '0;
				max_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) tally_q[i] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop && pop_item.action) begin
						ch_q    <= '0;
						state_q <= ST_PREP;
					end else if (sample) begin
						if (cnt_q != CNT_MAX) begin
							cnt_q <= cnt_q + 1'b1;
							for (int i = 0; i < NUM_SUM; i++) begin
								if (sum_n[i][SUM_W] != sum_n[i][SUM_W-1]) begin
									sum_q[i] <= sum_n[i][SUM_W] ?
										{1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
								end else begin
									sum_q[i] <= sum_n[i][SUM_W-1:0];
								end
							end
						end
						for (int i = 0; i < NUM_CH; i++) begin
							if (!has_q || v[i] < min_q[i]) min_q[i] <= v[i];
							if (!has_q || v[i] > max_q[i]) max_q[i] <= v[i];
						end
						has_q <= 1'b1;
						if (pop_item.colour != COL_NONE &&
							tally_q[pop_item.colour - 2'd1] != CNT_MAX) begin
							tally_q[pop_item.colour - 2'd1] <=
								tally_q[pop_item.colour - 2'd1] + 1'b1;
						end
					end
				end
				ST_PREP: begin
					step_q <= '0;
					if (has_div) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'(SUM_W - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						if (ch_q == CH_COLOUR) begin
							state_q <= ST_IDLE;
							cnt_q   <= '0;
							has_q   <= 1'b0;
							for (int i = 0; i < NUM_SUM; i++) sum_q[i] <= '0;
							for (int i = 0; i < NUM_CH; i++) begin
								min_q[i] <= '0;
								max_q[i] <= '0;
							end
							for (int i = 0; i < 3; i++) tally_q[i] <= '0;
						end else begin
							ch_q    <= ch_q + 3'd1;
							state_q <= ST_PREP;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			neg_q <= sum_sel < 0;
			dvd_q <= (sum_sel < 0) ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= rem_n[COUNT_BITS-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ch_q   <= ch_q;
			out_last_q <= ch_q == CH_COLOUR;
			if (ch_q == CH_COLOUR) begin
				out_data_q <= {cnt_out(dom_cnt), dom, cnt_out(cnt_q), {(3*VAL_W){1'b0}}};
			end else begin
				out_data_q <= {{OUT_CNT_W{1'b0}}, COL_NONE, cnt_out(cnt_q),
					mean_val, max_val, min_val};
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_ch_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = out_data_q;

endmodule

### src/sensor_window_statistics_core.sv
// Channel   Signals                               Moves
// s         s_tvalid s_tready s_tdata s_tuser     sensor sample or end-of-window request
// m         m_tvalid m_tready m_tdata m_tuser m_tlast   one statistics result per channel
// cfg       cfg_wen cfg_index cfg_data            limit register write
// A sample request leaves the queue and is accumulated into the state registers as it leaves.
// An end-of-window request emits eight results; each of channels 0..3 with a non-empty
// window passes PREP, DIV (bit-serial mean divider, one quotient bit a cycle) and EMIT,
// others PREP and EMIT.
// A two-entry queue parts intake from the back end; output stalls hold the back end,
// and the intake once the queue is full.
// arst_n clears the state and loads limit defaults 6000 and 100.
module sensor_window_statistics_core import swstat_pkg::*; #(
	parameter int COUNT_BITS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [183:0] s_tdata,  // light, moisture, temperature, humidity, accel x/y/z,
	                               // clear, red, green, blue
	input  logic         s_tuser,  // action
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,  // minimum, maximum, mean, sample_count, dominant_color,
	                               // color_count
	output logic [2:0]   m_tuser,  // channel
	output logic         m_tlast,
	input  logic         cfg_wen,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data
);

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	item_t   push_item;
	item_t   pop_item;

	swstat_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.s_tready  (s_tready),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	swstat_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_stat    (q_stat)
	);

	swstat_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop_item (pop_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.m_tdata  (m_tdata)
	);

	a_no_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_stat.empty)) else $error("pop from empty queue");

	a_last_is_colour: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == CH_COLOUR) else $error("last on wrong channel");

	a_colour_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[79:78] == COL_NONE && m_tdata[103:80] == '0)
		else $error("colour fields set on a channel result");

endmodule
